@@ sv/psb_pkg.sv @@
// shared types and constants for the point shell binning block
// no dependencies; imported by psb_axis, psb_shell_table and point_shell_binning_top
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

	localparam int OFS_W   = 32;
	localparam int HALF_W  = 31;
	localparam int RECIP_W = 32;
	localparam int TOL_W   = 16;
	localparam int CUT_W   = 6;
	localparam int SHELL_W = 6;
	localparam int ID_W    = 20;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int SHELL_CEIL = 63;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTER_X = 3'd0,
		REG_OUTER_Y = 3'd1,
		REG_OUTER_Z = 3'd2,
		REG_RECIP_X = 3'd3,
		REG_RECIP_Y = 3'd4,
		REG_RECIP_Z = 3'd5,
		REG_CUT     = 3'd6,
		REG_TOL     = 3'd7
	} cfg_reg_t;

	// load strobes for the two axis pipeline stages
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} axis_en_t;

	// per-axis result after the multiply stage
	typedef struct packed {
		logic               zero;
		logic [RECIP_W-1:0] quot;
	} axis_res_t;

	// shell table access strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} tbl_ctl_t;

endpackage

`default_nettype wire

@@ sv/psb_axis.sv @@
// one axis: depth against the outer half window, boundary test, reciprocal multiply
// depends on psb_pkg
`timescale 1ns / 1ps
`default_nettype none

module psb_axis (
	input  wire logic                                clk,
	input  wire psb_pkg::axis_en_t                   en,
	input  wire logic signed [psb_pkg::OFS_W-1:0]    offset,
	input  wire logic        [psb_pkg::HALF_W-1:0]   outer_half,
	input  wire logic        [psb_pkg::RECIP_W-1:0]  step_recip,
	input  wire logic        [psb_pkg::TOL_W-1:0]    tolerance,
	output psb_pkg::axis_res_t                       res_s2
);
	import psb_pkg::*;

	logic [OFS_W-1:0]     mag;
	logic [OFS_W:0]       depth;
	logic [OFS_W-1:0]     tol_ext;
	logic                 zero_c;
	logic [OFS_W-1:0]     sum_c;
	logic [OFS_W-1:0]     sum_s1;
	logic                 zero_s1;
	logic [2*RECIP_W-1:0] prod;

	// magnitude of the most negative offset is 2^31, still fits unsigned
	assign mag     = offset[OFS_W-1] ? (~offset + 32'd1) : offset;
	assign depth   = {2'b00, outer_half} - {1'b0, mag};
	assign tol_ext = {{(OFS_W-TOL_W){1'b0}}, tolerance};
	assign zero_c  = depth[OFS_W] || (depth[OFS_W-1:0] < tol_ext);
	assign sum_c   = depth[OFS_W-1:0] + tol_ext;

	always_ff @(posedge clk) begin
		if (en.ld_s1) begin
			sum_s1  <= sum_c;
			zero_s1 <= zero_c;
		end
	end

	assign prod = {{RECIP_W{1'b0}}, sum_s1} * {{OFS_W{1'b0}}, step_recip};

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			res_s2.zero <= zero_s1;
			res_s2.quot <= prod[2*RECIP_W-1:RECIP_W];
		end
	end

endmodule

`default_nettype wire

@@ sv/psb_shell_table.sv @@
// per-shell last fiber id memory with used bits and same-entry forwarding
// depends on psb_pkg
`timescale 1ns / 1ps
`default_nettype none

module psb_shell_table #(
	parameter int SHELL_COUNT = 64,
	parameter int SW          = $clog2(SHELL_COUNT)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire psb_pkg::tbl_ctl_t          ctl,
	input  wire logic [SW-1:0]              rd_shell,
	input  wire logic [SW-1:0]              wr_shell,
	input  wire logic [psb_pkg::ID_W-1:0]   wr_id,
	output logic                            first
);
	import psb_pkg::*;

	logic [ID_W-1:0]        mem [SHELL_COUNT];
	logic [ID_W-1:0]        rd_q;
	logic                   fwd_q;
	logic [ID_W-1:0]        fwd_id_q;
	logic [SHELL_COUNT-1:0] used_q;
	logic [ID_W-1:0]        last_id;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_shell] <= wr_id;
		end
		if (ctl.rd_en) begin
			rd_q     <= mem[rd_shell];
			fwd_id_q <= wr_id;
		end
	end

	// a read taken on the edge that writes the same entry sees old data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= 1'b0;
			used_q <= '0;
		end else begin
			if (ctl.rd_en) begin
				fwd_q <= ctl.wr_en && (rd_shell == wr_shell);
			end
			if (ctl.wr_en) begin
				used_q[wr_shell] <= 1'b1;
			end
		end
	end

	assign last_id = fwd_q ? fwd_id_q : rd_q;
	assign first   = !used_q[wr_shell] || (last_id != wr_id);

endmodule

`default_nettype wire

@@ sv/point_shell_binning_top.sv @@
// Point shell binning: accepts one point per cycle when the output side does not stall and
// returns one result per point in order. The pipeline is depth and boundary test, reciprocal
// multiply, shell minimum with the shell table read, then the output register; the per-shell
// id table does a read-modify-write for each point and forwards the id written on the edge
// of a read to the same shell.
// depends on psb_pkg, psb_axis, psb_shell_table
`timescale 1ns / 1ps
`default_nettype none

module point_shell_binning_top #(
	parameter int SHELL_COUNT = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [psb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [psb_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [psb_pkg::OFS_W-1:0]      offset_x,
	input  wire logic signed [psb_pkg::OFS_W-1:0]      offset_y,
	input  wire logic signed [psb_pkg::OFS_W-1:0]      offset_z,
	input  wire logic [psb_pkg::ID_W-1:0]              fiber_id,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [psb_pkg::SHELL_W-1:0]                shell_index,
	output logic                                       first_in_shell,
	output logic [psb_pkg::ID_W-1:0]                   echo_id
);
	import psb_pkg::*;

	localparam int SW = $clog2(SHELL_COUNT);
	localparam int MAX_SHELL = (SHELL_COUNT - 1 < SHELL_CEIL) ? SHELL_COUNT - 1 : SHELL_CEIL;

	logic [HALF_W-1:0]  outer_half_q [3];
	logic [RECIP_W-1:0] step_recip_q [3];
	logic [CUT_W-1:0]   cut_count_q;
	logic [TOL_W-1:0]   tolerance_q;

	logic vld_s1, vld_s2, vld_s3;
	logic mv1, mv2, mv3, out_free, acc;
	logic [ID_W-1:0]    id_s1, id_s2, id_s3;
	logic [SHELL_W-1:0] shell_s3;
	logic [CUT_W:0]     lim_full;
	logic [SHELL_W-1:0] lim;
	logic [SHELL_W-1:0] ax_shell [3];
	logic [SHELL_W-1:0] shell_c;
	logic               first_c;

	axis_en_t           ax_en;
	axis_res_t          ax_res [3];
	tbl_ctl_t           tbl_ctl;
	logic signed [OFS_W-1:0] ofs [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				outer_half_q[a] <= '0;
				step_recip_q[a] <= 32'd65536;
			end
			cut_count_q <= '0;
			tolerance_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OUTER_X: outer_half_q[0] <= cfg_data[HALF_W-1:0];
				REG_OUTER_Y: outer_half_q[1] <= cfg_data[HALF_W-1:0];
				REG_OUTER_Z: outer_half_q[2] <= cfg_data[HALF_W-1:0];
				REG_RECIP_X: step_recip_q[0] <= cfg_data[RECIP_W-1:0];
				REG_RECIP_Y: step_recip_q[1] <= cfg_data[RECIP_W-1:0];
				REG_RECIP_Z: step_recip_q[2] <= cfg_data[RECIP_W-1:0];
				REG_CUT:     cut_count_q     <= cfg_data[CUT_W-1:0];
				REG_TOL:     tolerance_q     <= cfg_data[TOL_W-1:0];
			endcase
		end
	end

	// pipeline flow control
	assign out_free = !out_valid || out_ready;
	assign mv3      = vld_s3 && out_free;
	assign mv2      = vld_s2 && (!vld_s3 || mv3);
	assign mv1      = vld_s1 && (!vld_s2 || mv2);
	assign in_ready = !vld_s1 || mv1;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (!vld_s2 || mv2) vld_s2 <= mv1;
			if (!vld_s3 || mv3) vld_s3 <= mv2;
			if (out_free) out_valid <= mv3;
		end
	end

	assign ax_en.ld_s1 = acc;
	assign ax_en.ld_s2 = mv1;
	assign ofs[0] = offset_x;
	assign ofs[1] = offset_y;
	assign ofs[2] = offset_z;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		psb_axis u_axis (
			.clk        (clk),
			.en         (ax_en),
			.offset     (ofs[a]),
			.outer_half (outer_half_q[a]),
			.step_recip (step_recip_q[a]),
			.tolerance  (tolerance_q),
			.res_s2     (ax_res[a])
		);
	end

	// innermost shell allowed by the cut count and by the table depth
	assign lim_full = {1'b0, cut_count_q} + 7'd1;
	assign lim = (lim_full > 7'(MAX_SHELL)) ? SHELL_W'(MAX_SHELL) : lim_full[SHELL_W-1:0];

	always_comb begin
		logic [RECIP_W:0] q1;
		for (int a = 0; a < 3; a++) begin
			q1 = {1'b0, ax_res[a].quot} + 33'd1;
			if (ax_res[a].zero) begin
				ax_shell[a] = '0;
			end else if (q1 > {{(RECIP_W+1-SHELL_W){1'b0}}, lim}) begin
				ax_shell[a] = lim;
			end else begin
				ax_shell[a] = q1[SHELL_W-1:0];
			end
		end
		shell_c = ax_shell[0];
		if (ax_shell[1] < shell_c) shell_c = ax_shell[1];
		if (ax_shell[2] < shell_c) shell_c = ax_shell[2];
	end

	always_ff @(posedge clk) begin
		if (acc) id_s1 <= fiber_id;
		if (mv1) id_s2 <= id_s1;
		if (mv2) begin
			id_s3    <= id_s2;
			shell_s3 <= shell_c;
		end
		if (mv3) begin
			shell_index    <= shell_s3;
			first_in_shell <= first_c;
			echo_id        <= id_s3;
		end
	end

	assign tbl_ctl.rd_en = mv2;
	assign tbl_ctl.wr_en = mv3;

	psb_shell_table #(
		.SHELL_COUNT (SHELL_COUNT),
		.SW          (SW)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.rd_shell (SW'(shell_c)),
		.wr_shell (SW'(shell_s3)),
		.wr_id    (id_s3),
		.first    (first_c)
	);

	// shell never beyond the configured innermost shell
	a_shell_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shell_index <= lim))
		else $error("shell index beyond limit");

	// back-to-back transfers of one id into one shell never flag the second as first
	a_repeat_id: assert property (@(posedge clk) disable iff (!arst_n)
		(mv3 && $past(mv3) && (shell_s3 == $past(shell_s3)) && (id_s3 == $past(id_s3)))
		|-> !first_c)
		else $error("repeated id flagged as first");

	// a stage-3 transfer always lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		mv3 |=> out_valid)
		else $error("result lost at output register");

endmodule

`default_nettype wire
